// ===== src/lis_pkg.sv =====
// Shared types and constants for the longest increasing subsequence length block.
`timescale 1ns / 1ps
package lis_pkg;

  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int KEY_W   = 64;
  localparam int POS_W   = 10;
  localparam int LEN_W   = 11;
  localparam int OUT_W   = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_PROBE,
    ST_FINISH
  } lis_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic probe;
    logic commit;
  } lis_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic more;
    logic out_free;
  } lis_sts_t;

endpackage

// ===== src/lis_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module lis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lis_ctrl.sv =====
// Controller state machine: accept, binary-search probes, commit.
`timescale 1ns / 1ps
module lis_ctrl import lis_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  lis_sts_t sts,
  output lis_cmd_t cmd
);

  lis_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = sts.more ? ST_PROBE : ST_FINISH;
      end
      ST_PROBE: begin
        // compare the returned tail and launch the next probe in the same cycle
        cmd.probe = 1'b1;
        cmd.issue = 1'b1;
        state_nxt = sts.more ? ST_PROBE : ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/lis_dp.sv =====
// Datapath: tail table, search bounds, tail count and output register.
`timescale 1ns / 1ps
module lis_dp import lis_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] in_value,
  input  logic             in_start,
  input  lis_cmd_t         cmd,
  output lis_sts_t         sts,
  input  logic             out_tready,
  output logic             out_valid,
  output logic [POS_W-1:0] out_pos,
  output logic [LEN_W-1:0] out_len
);

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_LEN);
  localparam logic [POS_W-1:0] FULL_POS = POS_W'(MAX_LEN - 1);

  logic [KEY_W-1:0]  key_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0]  lo_eval, hi_eval;
  logic [CNT_W:0]    mid_sum;
  logic [KEY_W-1:0]  rdata;
  logic              tail_less;
  logic              ram_we;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r;
  logic [LEN_W-1:0]  out_len_r;

  // unsigned compare on sign-flipped keys gives signed order
  assign tail_less = rdata < key_r;

  always_comb begin
    lo_eval = lo_r;
    hi_eval = hi_r;
    if (cmd.probe) begin
      if (tail_less) begin
        lo_eval = CNT_W'({1'b0, mid_r}) + CNT_W'(1);
      end else begin
        hi_eval = CNT_W'({1'b0, mid_r});
      end
    end
  end

  assign mid_sum = {1'b0, lo_eval} + {1'b0, hi_eval};
  assign mid_nxt = mid_sum[ADDR_W:1];

  assign sts.more     = lo_eval < hi_eval;
  assign sts.out_free = !out_valid_r || out_tready;

  always_comb begin
    lo_nxt = lo_eval;
    hi_nxt = hi_eval;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      lo_nxt  = '0;
      hi_nxt  = in_start ? '0 : cnt_r;
      cnt_nxt = in_start ? '0 : cnt_r;
    end else if (cmd.commit && lo_r >= cnt_r && cnt_r < MAX_CNT) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // write when replacing a tail or appending below the size limit
  assign ram_we = cmd.commit && (lo_r < cnt_r || cnt_r < MAX_CNT);

  lis_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_LEN)
  ) u_tail_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lo_r[ADDR_W-1:0]),
    .wdata (key_r),
    .re    (cmd.issue && sts.more),
    .raddr (mid_nxt),
    .rdata (rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.load) begin
      key_r <= {~in_value[KEY_W-1], in_value[KEY_W-2:0]};
    end
    if (cmd.issue) begin
      mid_r <= mid_nxt;
    end
    if (cmd.commit) begin
      out_pos_r <= (lo_r >= MAX_CNT) ? FULL_POS : lo_r[POS_W-1:0];
      out_len_r <= LEN_W'(cnt_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos   = out_pos_r;
  assign out_len   = out_len_r;

endmodule

// ===== src/longest_increasing_subsequence_length_top.sv =====
// Longest strictly increasing subsequence length, binary search over a tail RAM.
// Each input word runs p RAM probes, between floor(log2(n + 1)) and
// ceil(log2(n + 1)) for n tails searched (zero after a start), before its result
// word is offered; a result still held on the output adds its wait.
// No new word is accepted until the current one is committed. Reset (rst_n low, synchronous)
// empties the tail count and the output; the tail RAM itself is not cleared.
`timescale 1ns / 1ps
module longest_increasing_subsequence_length_top import lis_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [KEY_W-1:0] in_tdata,   // [63:0] value
  input  logic             in_tuser,   // [0] start_req
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [9:0] insert_pos, [20:10] lis_length, rest zero
);

  lis_cmd_t         cmd;
  lis_sts_t         sts;
  logic [POS_W-1:0] out_pos;
  logic [LEN_W-1:0] out_len;

  lis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lis_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata),
    .in_start   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_pos    (out_pos),
    .out_len    (out_len)
  );

  assign out_tdata = {{(OUT_W - POS_W - LEN_W){1'b0}}, out_len, out_pos};

endmodule

// ===== verif/lis_length_checker.sv =====
// Scoreboard for the LIS length block: mirrors the tail table and checks every result word.
`timescale 1ns / 1ps
module lis_length_checker import lis_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [KEY_W-1:0] in_tdata,
  input  logic             in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               mismatches,
  output int               pending,
  output int               results_seen,
  output int               peak_length,
  output int               full_table_hits
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [OUT_W-LEN_W-POS_W-1:0] pad;
    logic [LEN_W-1:0]             len;
    logic [POS_W-1:0]             pos;
  } placement_t;

  logic signed [KEY_W-1:0] tails [MAX_LEN];
  int                      tail_total = 0;
  placement_t              placements_q [$];

  // Patience step: find the first tail not less than the value, replace or append.
  function automatic placement_t place_value(input logic signed [KEY_W-1:0] v,
                                             input logic restart);
    int         lo;
    int         hi;
    int         mid;
    placement_t r;
    if (restart) tail_total = 0;
    lo = 0;
    hi = tail_total;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (tails[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    if (lo < tail_total) begin
      tails[lo] = v;
    end else if (tail_total < MAX_LEN) begin
      tails[tail_total] = v;
      tail_total++;
    end else begin
      // table full: nothing stored, report the last slot
      lo = MAX_LEN - 1;
    end
    r.pad = '0;
    r.len = LEN_W'(tail_total);
    r.pos = POS_W'(lo);
    return r;
  endfunction

  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    if (!rst_n) begin
      tail_total = 0;
      placements_q.delete();
    end else begin
      // check the outgoing word before booking the incoming one
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        results_seen++;
        if (placements_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result word slot=%0d len=%0d pad=%0h",
                     $time, got.pos, got.len, got.pad);
        end else begin
          want = placements_q.pop_front();
          if (got.pos !== want.pos || got.len !== want.len || got.pad !== want.pad) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result %0d slot=%0d len=%0d pad=%0h, expected slot=%0d len=%0d pad=0",
                       $time, results_seen, got.pos, got.len, got.pad, want.pos, want.len);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = place_value(in_tdata, in_tuser);
        placements_q.push_back(want);
        if (want.len == MAX_LEN) full_table_hits++;
        if (int'(want.len) > peak_length) peak_length = int'(want.len);
      end
    end
    pending = placements_q.size();
  end

endmodule

// ===== verif/longest_increasing_subsequence_length_top_test.sv =====
// Testbench top for the LIS length block: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps
module longest_increasing_subsequence_length_top_test;
  import lis_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int FILL_EXTRA   = 8;
  localparam logic [KEY_W-1:0] KEY_MIN = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum int {RUN_RANDOM, RUN_RISING, RUN_FALLING, RUN_NARROW, RUN_NOISE} run_kind_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [KEY_W-1:0] in_tdata   = '0;
  logic             in_tuser   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  int send_idle_pct = 8;
  int recv_idle_pct = 81;
  int words_sent    = 0;
  int stall_cycles  = 0;
  int mismatches;
  int pending;
  int results_seen;
  int peak_length;
  int full_table_hits;

  longest_increasing_subsequence_length_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lis_length_checker placement_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_seen    (results_seen),
    .peak_length     (peak_length),
    .full_table_hits (full_table_hits)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Random backpressure on the result side.
  initial begin
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
    else stall_cycles++;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] extreme_key();
    case ($urandom_range(0, 3))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Drive one word at the falling edge and hold it until accepted.
  task automatic send_word(input logic [KEY_W-1:0] v, input logic restart);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = v;
    in_tuser  = restart;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic short_runs(input int quota);
    int                      done;
    int                      run_len;
    int                      k;
    run_kind_t               kind;
    logic                    restart;
    logic                    flag;
    logic signed [KEY_W-1:0] v;
    done = 0;
    while (done < quota) begin
      kind    = run_kind_t'($urandom_range(0, 4));
      run_len = $urandom_range(1, 40);
      restart = ($urandom_range(0, 9) != 0);
      v       = rand_key();
      for (k = 0; k < run_len; k++) begin
        case (kind)
          RUN_RANDOM:  v = rand_key();
          RUN_RISING:  v = ($urandom_range(0, 7) == 0) ? v - $urandom_range(0, 1000)
                                                       : v + $urandom_range(1, 1000);
          RUN_FALLING: v = v - $urandom_range(0, 1000);
          RUN_NARROW:  v = int'($urandom_range(0, 16)) - 8;
          RUN_NOISE:   v = ($urandom_range(0, 1) != 0) ? rand_key() : extreme_key();
          default:     v = rand_key();
        endcase
        flag = (k == 0 && restart) || (kind == RUN_NOISE && $urandom_range(0, 3) == 0);
        send_word(v, flag);
        done++;
      end
    end
  endtask

  // Climb until the table saturates, with dips and repeats mixed in, then push past it.
  task automatic fill_table();
    int                      rising;
    int                      pick;
    logic signed [KEY_W-1:0] peak_v;
    peak_v = 64'hC000_0000_0000_0000 + $urandom;
    send_word(peak_v, 1'b1);
    rising = 1;
    while (rising < MAX_LEN + FILL_EXTRA) begin
      pick = $urandom_range(0, 49);
      if (pick == 0) begin
        send_word(peak_v - $urandom_range(0, 1 << 20), 1'b0);
      end else if (pick == 1) begin
        send_word(peak_v, 1'b0);
      end else begin
        peak_v = peak_v + $urandom_range(1, 32'hFFFF_FFFF);
        send_word(peak_v, 1'b0);
        rising++;
      end
    end
    send_word(peak_v, 1'b0);
    send_word(KEY_MAX, 1'b0);
    send_word(KEY_MAX, 1'b0);
    send_word(KEY_MIN, 1'b0);
    send_word(rand_key(), 1'b0);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // empty table without a restart, extremes, equal values, restarts
    send_word('0, 1'b0);
    send_word(KEY_MIN, 1'b1);
    send_word(KEY_MAX, 1'b0);
    send_word(KEY_MAX, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(KEY_MIN, 1'b0);
    send_word(64'd1, 1'b0);
    send_word(64'd2, 1'b0);
    send_word(64'd3, 1'b0);
    send_word(64'h5555_5555_5555_5555, 1'b0);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word(64'd5, 1'b1);
    send_word(64'd4, 1'b0);
    send_word(64'd3, 1'b0);
    send_word(64'd2, 1'b0);
    send_word(KEY_MAX, 1'b1);
    send_word(KEY_MIN, 1'b0);
    send_word('0, 1'b1);
    send_word('0, 1'b0);
    send_word(64'h0000_0001_0000_0000, 1'b0);

    short_runs(16);

    send_idle_pct = 81;
    recv_idle_pct = 8;
    fill_table();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    short_runs(16);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words, %0d results; peak length %0d, %0d results on a full table",
             words_sent, results_seen, peak_length, full_table_hits);
    $display("Stimulus: extremes, ties, restarts, rising/falling/narrow/noisy runs");
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
